// ----- src/template_to_script_converter_assert.svh -----
// Assertion macros shared by the template converter modules.
`ifndef TEMPLATE_TO_SCRIPT_CONVERTER_ASSERT_SVH
`define TEMPLATE_TO_SCRIPT_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TTSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TTSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Invariant that holds on every clock edge out of reset.
`define TTSC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("%m: check failed");

`endif

// ----- src/ttsc_pkg.sv -----
// Types, character codes and fixed script strings of the template converter.
package ttsc_pkg;

    // Character codes
    localparam logic [7:0] C_LT   = 8'h3C;
    localparam logic [7:0] C_GT   = 8'h3E;
    localparam logic [7:0] C_STAR = 8'h2A;
    localparam logic [7:0] C_EQ   = 8'h3D;
    localparam logic [7:0] C_CR   = 8'h0D;
    localparam logic [7:0] C_LF   = 8'h0A;
    localparam logic [7:0] C_BSL  = 8'h5C;
    localparam logic [7:0] C_DQ   = 8'h22;
    localparam logic [7:0] C_TAB  = 8'h09;
    localparam logic [7:0] C_SP   = 8'h20;
    localparam logic [7:0] C_RPAR = 8'h29;
    localparam logic [7:0] C_LC_R = 8'h72;
    localparam logic [7:0] C_LC_N = 8'h6E;

    // Fixed strings, first character in the top byte
    localparam logic [4*8-1:0]  S_CLOSE = "\" )\n";
    localparam logic [14*8-1:0] S_OPEN  = "\nhttpWrite ( \"";
    localparam logic [12*8-1:0] S_SH    = "httpWrite ( ";
    localparam logic [4*8-1:0]  S_END   = "\nend";

    localparam logic [3:0] LEN_CLOSE = 4'd4;
    localparam logic [3:0] LEN_OPEN  = 4'd14;
    localparam logic [3:0] LEN_SH    = 4'd12;
    localparam logic [3:0] LEN_END   = 4'd4;

    // String emitted by a byte
    typedef enum logic [1:0] {
        STR_NONE,
        STR_CLOSE,
        STR_OPEN,
        STR_SH
    } t_str;

    // Output segments in emission order
    typedef enum logic [1:0] {
        PH_LIT,
        PH_STR,
        PH_CLOSE,
        PH_END
    } t_phase;

    // Work for one accepted byte, handed from front to back
    typedef struct packed {
        logic [1:0] lit_cnt;
        logic [7:0] lit0;
        logic [7:0] lit1;
        t_str       str;
        logic       tail_close;
        logic       tail_end;
    } t_desc;

    function automatic logic [3:0] str_len(t_str sel);
        logic [3:0] len;
        len = '0;
        unique case (sel)
            STR_NONE:  len = '0;
            STR_CLOSE: len = LEN_CLOSE;
            STR_OPEN:  len = LEN_OPEN;
            STR_SH:    len = LEN_SH;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] close_byte(logic [1:0] idx);
        return S_CLOSE[8*(3-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] end_byte(logic [1:0] idx);
        return S_END[8*(3-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] str_byte(t_str sel, logic [3:0] idx);
        logic [7:0] b;
        b = '0;
        unique case (sel)
            STR_NONE:  b = '0;
            STR_CLOSE: b = close_byte(idx[1:0]);
            STR_OPEN: begin
                if (idx < LEN_OPEN) b = S_OPEN[8*(13-int'(idx)) +: 8];
            end
            STR_SH: begin
                if (idx < LEN_SH) b = S_SH[8*(11-int'(idx)) +: 8];
            end
        endcase
        return b;
    endfunction

endpackage

// ----- src/ttsc_front.sv -----
// Front end: accepts template bytes, tracks mode state and classifies each byte.
`include "template_to_script_converter_assert.svh"

module ttsc_front import ttsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_desc      o_desc
);

    typedef struct packed {
        logic in_code;
        logic block_just_opened;
        logic shorthand_open;
        logic open_pending;
        logic close_pending;
    } t_state;

    t_state r_st;
    t_state n_st;
    t_state s_nxt;
    t_desc  s_desc;
    logic   s_accept;

    assign s_accept = i_push && !i_q_full;

    // Classify the byte against the current mode
    always_comb begin
        s_nxt  = r_st;
        s_desc = '{lit_cnt: 2'd0, lit0: i_in_byte, lit1: i_in_byte, str: STR_NONE,
                   tail_close: 1'b0, tail_end: 1'b0};
        if (!r_st.in_code) begin
            if (r_st.open_pending) begin
                s_nxt.open_pending = 1'b0;
                if (i_in_byte == C_STAR) begin
                    s_nxt.in_code           = 1'b1;
                    s_nxt.block_just_opened = 1'b1;
                    s_desc.str              = STR_CLOSE;
                end else begin
                    s_desc.lit_cnt = 2'd2;
                    s_desc.lit0    = C_LT;
                end
            end else if (i_in_byte == C_LT) begin
                s_nxt.open_pending = 1'b1;
            end else if (i_in_byte == C_CR) begin
                s_desc.lit_cnt = 2'd2;
                s_desc.lit0    = C_BSL;
                s_desc.lit1    = C_LC_R;
            end else if (i_in_byte == C_LF) begin
                s_desc.lit_cnt = 2'd2;
                s_desc.lit0    = C_BSL;
                s_desc.lit1    = C_LC_N;
            end else if (i_in_byte == C_BSL || i_in_byte == C_DQ) begin
                s_desc.lit_cnt = 2'd2;
                s_desc.lit0    = C_BSL;
            end else begin
                s_desc.lit_cnt = 2'd1;
            end
        end else begin
            if (r_st.close_pending) begin
                s_nxt.close_pending = 1'b0;
                if (i_in_byte == C_GT) begin
                    s_nxt.in_code = 1'b0;
                    s_desc.str    = STR_OPEN;
                    if (r_st.shorthand_open) begin
                        s_nxt.shorthand_open = 1'b0;
                        s_desc.lit_cnt       = 2'd1;
                        s_desc.lit0          = C_RPAR;
                    end
                end else begin
                    s_desc.lit_cnt = 2'd2;
                    s_desc.lit0    = C_STAR;
                end
            end else if (i_in_byte == C_STAR) begin
                s_nxt.close_pending = 1'b1;
            end else if (i_in_byte == C_EQ && r_st.block_just_opened) begin
                s_desc.str           = STR_SH;
                s_nxt.shorthand_open = 1'b1;
            end else begin
                if (i_in_byte != C_TAB && i_in_byte != C_SP) begin
                    s_nxt.block_just_opened = 1'b0;
                end
                s_desc.lit_cnt = 2'd1;
            end
        end

        // Flush a dangling marker and add the closing tail on the last byte
        if (i_is_final) begin
            if (s_nxt.open_pending) begin
                s_desc.lit_cnt = 2'd1;
                s_desc.lit0    = C_LT;
            end else if (s_nxt.close_pending) begin
                s_desc.lit_cnt = 2'd1;
                s_desc.lit0    = C_STAR;
            end
            s_desc.tail_close = !s_nxt.in_code;
            s_desc.tail_end   = 1'b1;
        end
    end

    // Queue only bytes that produce output
    assign o_desc   = s_desc;
    assign o_q_push = s_accept && (s_desc.lit_cnt != 2'd0 || s_desc.str != STR_NONE
                                   || i_is_final);

    // Advance mode state; restart after the last byte
    always_comb begin
        n_st = r_st;
        if (s_accept) begin
            n_st = i_is_final ? '0 : s_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    `TTSC_ASSERT_ALWAYS(a_pending_mode, r_st.in_code ? !r_st.open_pending : !r_st.close_pending)

endmodule

// ----- src/ttsc_fifo.sv -----
// Descriptor queue between the front end and the output sequencer.
`include "template_to_script_converter_assert.svh"

module ttsc_fifo import ttsc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_desc             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              s_wr;
    logic              s_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (s_wr && !s_rd) begin
            n_count = r_count + 1'b1;
        end else if (s_rd && !s_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `TTSC_ASSERT_IMP(a_no_push_when_full, i_push, !o_full)
    `TTSC_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH))

endmodule

// ----- src/ttsc_back.sv -----
// Back end: expands queued descriptors into script bytes, one per cycle while the output is not stalled.
`include "template_to_script_converter_assert.svh"

module ttsc_back import ttsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_desc      i_desc,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_script_end
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_script_end;

    logic [3:0] s_mask;
    t_phase     s_eff;
    logic       s_has_next;
    t_phase     s_next;
    logic [3:0] s_seg_len;
    logic [7:0] s_byte;
    logic       s_seg_last;
    logic       s_desc_last;
    logic       s_adv;

    // Segments present in the head descriptor
    assign s_mask = {i_desc.tail_end, i_desc.tail_close, i_desc.str != STR_NONE,
                     i_desc.lit_cnt != 2'd0};

    // Pick the current segment and the one after it
    always_comb begin
        logic found;
        found      = 1'b0;
        s_eff      = PH_LIT;
        s_has_next = 1'b0;
        s_next     = PH_LIT;
        for (int p = 0; p < 4; p++) begin
            if (!found && p >= int'(r_phase) && s_mask[p]) begin
                s_eff = t_phase'(p[1:0]);
                found = 1'b1;
            end
        end
        for (int p = 0; p < 4; p++) begin
            if (!s_has_next && p > int'(s_eff) && s_mask[p]) begin
                s_next     = t_phase'(p[1:0]);
                s_has_next = 1'b1;
            end
        end
    end

    // Select the byte of the current segment
    always_comb begin
        s_seg_len = '0;
        s_byte    = '0;
        unique case (s_eff)
            PH_LIT: begin
                s_seg_len = {2'b00, i_desc.lit_cnt};
                s_byte    = r_idx[0] ? i_desc.lit1 : i_desc.lit0;
            end
            PH_STR: begin
                s_seg_len = str_len(i_desc.str);
                s_byte    = str_byte(i_desc.str, r_idx);
            end
            PH_CLOSE: begin
                s_seg_len = LEN_CLOSE;
                s_byte    = close_byte(r_idx[1:0]);
            end
            PH_END: begin
                s_seg_len = LEN_END;
                s_byte    = end_byte(r_idx[1:0]);
            end
        endcase
    end

    assign s_seg_last  = (r_idx == s_seg_len - 1'b1);
    assign s_desc_last = s_seg_last && !s_has_next;
    assign s_adv       = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop     = s_adv && s_desc_last;

    // Step through segments; restart at the literal segment per descriptor
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (s_adv) begin
            n_out_valid = 1'b1;
            if (s_desc_last) begin
                n_phase = PH_LIT;
                n_idx   = '0;
            end else if (s_seg_last) begin
                n_phase = s_next;
                n_idx   = '0;
            end else begin
                n_phase = s_eff;
                n_idx   = r_idx + 1'b1;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LIT;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_byte   <= s_byte;
            r_run_last   <= s_desc_last;
            r_script_end <= s_desc_last && i_desc.tail_end;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_script_end = r_script_end;

    `TTSC_ASSERT_NXT(a_seq_restart, s_adv && s_desc_last, r_phase == PH_LIT && r_idx == '0)
    `TTSC_ASSERT_IMP(a_end_is_last, r_out_valid && r_script_end, r_run_last)

endmodule

// ----- src/template_to_script_converter.sv -----
// Top level of the template to script converter.
//
//  Channel   Direction  Handshake         Fields
//  input     in         push / full       i_in_byte, i_is_final
//  result    out        empty / pop       o_out_byte, o_run_last, o_script_end
//
//  A byte is taken every cycle while the descriptor queue has room; the front end
//  classifies it in the cycle it is accepted and queues its descriptor. The output
//  sequencer emits one script byte per cycle while the output is not stalled, and
//  a byte expands to 0 to 23 script bytes.
//  Reset is synchronous, active low, and clears mode state, queue and output.
//  A stalled pop holds the output; the queue absorbs long expansions until full.
module template_to_script_converter import ttsc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_script_end
);

    logic  s_q_push;
    logic  s_q_pop;
    logic  s_q_full;
    logic  s_q_empty;
    t_desc s_desc_in;
    t_desc s_desc_out;

    assign full = s_q_full;

    // Classify incoming bytes
    ttsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .i_q_full   (s_q_full),
        .o_q_push   (s_q_push),
        .o_desc     (s_desc_in)
    );

    // Decouple front and back
    ttsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_q_push),
        .i_data  (s_desc_in),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_data  (s_desc_out),
        .o_empty (s_q_empty)
    );

    // Expand descriptors into output transfers
    ttsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (s_q_empty),
        .i_desc       (s_desc_out),
        .o_q_pop      (s_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_script_end (o_script_end)
    );

endmodule
